FILE: rtl/b64e_pkg.sv
// Shared types, constants and the character lookup for the base64 encoder.
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2,
        PHASE_SPARE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out_item;

    // One byte's worth of characters, handed from front to back.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            mark_last;
    } t_entry;

    // Map a 6-bit value onto the standard alphabet.
    function automatic logic [6:0] b64e_sym(input logic [5:0] v);
        logic [6:0] c;
        c = 7'd0;
        if (v < 6'd26) begin
            c = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'd71 + {1'b0, v};
        end else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

FILE: rtl/base64_encoder_top.sv
// Top level of the streaming base64 encoder.
//
// Input channel: one raw byte per transaction with a flag on the last byte
// of the message (i_in_valid / i_in_data, stalled by o_in_stall).
// Output channel: one ASCII character per transaction, base64 symbol or '='
// pad, with a flag on the final character (o_out_valid / o_out_data,
// stalled by i_out_stall).
// A front end tracks the position within the 3-byte group and the leftover
// bits of the previous byte, and turns each byte into an entry of one to four
// characters. A two-entry queue decouples it from the back end, which emits
// one character per cycle from a registered output stage unless stalled.
// The first character of a byte passes through the queue and then the
// output register before the receiver can take it.
// Throughput: one character per cycle while the receiver does not stall,
// set by the output register; sustained input averages four characters
// per three bytes, and a final byte yields up to four characters.
// Reset clears the group position, leftover bits, queue and output valid.
// When the receiver stalls, the output character holds, the queue fills
// and then o_in_stall rises until the back end drains an entry.
module base64_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  b64e_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output b64e_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import b64e_pkg::*;

    logic   push, pop, q_full, q_valid;
    t_entry push_entry, head_entry;

    // Stall the sender only while the queue holds no free slot.
    assign o_in_stall = q_full;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: rtl/b64e_front.sv
// Front end: accept bytes, track the group position and build character entries.
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  b64e_pkg::t_in_item  i_in_data,
    input  logic                i_q_full,
    output logic                o_push,
    output b64e_pkg::t_entry    o_entry
);
    import b64e_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [7:0] b;
    logic       last;

    assign b      = i_in_data.data_byte;
    assign last   = i_in_data.last_byte;
    assign o_push = i_in_valid && !i_q_full;

    always_comb begin
        o_entry   = '0;
        n_phase   = PHASE_FIRST;
        n_carry   = 4'd0;
        unique case (r_phase)
            PHASE_SECOND: begin
                o_entry.chars[0] = b64e_sym({r_carry[1:0], b[7:4]});
                if (last) begin
                    o_entry.chars[1]  = b64e_sym({b[3:0], 2'b00});
                    o_entry.chars[2]  = PAD_CHAR;
                    o_entry.last_idx  = 2'd2;
                    o_entry.mark_last = 1'b1;
                end else begin
                    n_carry = b[3:0];
                    n_phase = PHASE_THIRD;
                end
            end
            PHASE_THIRD: begin
                o_entry.chars[0]  = b64e_sym({r_carry, b[7:6]});
                o_entry.chars[1]  = b64e_sym(b[5:0]);
                o_entry.last_idx  = 2'd1;
                o_entry.mark_last = last;
            end
            PHASE_FIRST, PHASE_SPARE: begin
                o_entry.chars[0] = b64e_sym(b[7:2]);
                if (last) begin
                    o_entry.chars[1]  = b64e_sym({b[1:0], 4'b0000});
                    o_entry.chars[2]  = PAD_CHAR;
                    o_entry.chars[3]  = PAD_CHAR;
                    o_entry.last_idx  = 2'd3;
                    o_entry.mark_last = 1'b1;
                end else begin
                    n_carry = {2'b00, b[1:0]};
                    n_phase = PHASE_SECOND;
                end
            end
            default: begin
                n_phase = PHASE_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_FIRST;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

FILE: rtl/b64e_queue.sv
// Short entry queue between the front end and the character serializer.
module b64e_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64e_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output b64e_pkg::t_entry  o_entry
);
    import b64e_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_entry          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/b64e_back.sv
// Back end: serialize queued entries into one character per cycle while the output is not stalled.
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  b64e_pkg::t_entry    i_q_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    output b64e_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import b64e_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_data;
    logic       load;
    logic       at_end;

    assign load        = i_q_valid && (!r_valid || !i_out_stall);
    assign at_end      = (r_idx == i_q_entry.last_idx);
    assign o_pop       = load && at_end;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_char  <= i_q_entry.chars[r_idx];
            r_data.last_char <= at_end && i_q_entry.mark_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: sim/base64_encoder_top_tb.sv
// Self-checking testbench for the streaming base64 encoder top level.
`timescale 1ns / 1ps

module base64_encoder_top_tb;

    import b64e_pkg::*;

    // Standard alphabet, first character in the top byte.
    localparam logic [64*8-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    // Encoder state as predicted from the accepted byte stream.
    t_phase     enc_phase = PHASE_FIRST;
    logic [3:0] enc_carry = 4'd0;

    // Characters still owed by the block, oldest first.
    t_out_item  pending_chars[$];

    int  mismatch_count  = 0;
    int  idle_cycles     = 0;
    int  hold_cycles_req = 0;
    bit  tx_idle_en      = 1'b0;
    bit  rx_idle_en      = 1'b0;

    base64_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [6:0] alphabet_char(input logic [5:0] v);
        return ALPHABET[(63 - v) * 8 +: 7];
    endfunction

    task automatic push_char(input logic [6:0] ch, input logic is_last);
        t_out_item item;
        item.out_char  = ch;
        item.last_char = is_last;
        pending_chars.push_back(item);
    endtask

    // Advance the group position by one accepted byte and queue the
    // characters it produces. The spare phase encoding behaves like the
    // first phase, although the byte stream can never drive it there.
    task automatic encode_byte(input t_in_item item);
        logic [7:0] b;
        b = item.data_byte;
        case (enc_phase)
            PHASE_SECOND: begin
                push_char(alphabet_char({enc_carry[1:0], b[7:4]}), 1'b0);
                if (item.last_byte) begin
                    push_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                    enc_phase = PHASE_FIRST;
                    enc_carry = 4'd0;
                end else begin
                    enc_carry = b[3:0];
                    enc_phase = PHASE_THIRD;
                end
            end
            PHASE_THIRD: begin
                push_char(alphabet_char({enc_carry, b[7:6]}), 1'b0);
                push_char(alphabet_char(b[5:0]), item.last_byte);
                enc_phase = PHASE_FIRST;
                enc_carry = 4'd0;
            end
            default: begin
                push_char(alphabet_char(b[7:2]), 1'b0);
                if (item.last_byte) begin
                    push_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                    enc_phase = PHASE_FIRST;
                    enc_carry = 4'd0;
                end else begin
                    enc_carry = {2'b00, b[1:0]};
                    enc_phase = PHASE_SECOND;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. Valid stays high
    // afterwards so back-to-back transactions need no extra assignment;
    // only an idle burst drops it.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        t_in_item item;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        item.data_byte = value;
        item.last_byte = is_last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        encode_byte(item);
    endtask

    // Send up to four bytes as one message, first byte in the top lane.
    task automatic send_message(input logic [31:0] bytes, input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(bytes[31 - 8 * i -: 8], i == len - 1);
        end
    endtask

    task automatic send_random_message(input int len);
        logic [7:0] value;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = 8'($urandom_range(0, 255));
            endcase
            send_byte(value, i == len - 1);
        end
    endtask

    // Drop valid and wait until every owed character has arrived. The loop
    // waits on the clock before it tests, so valid is never lowered and raised in one step.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Random stall bursts, or one long hold when a test asks for it.
    initial begin : receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_req > 0) begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted character with the oldest owed one. Values
    // read here are the ones present at the edge, before any update.
    always @(posedge i_clk) begin : check_chars
        t_out_item owed;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("[%0t] unexpected character: char=%h last=%b",
                             $realtime, o_out_data.out_char, o_out_data.last_char);
                end
            end else begin
                owed = pending_chars.pop_front();
                if (o_out_data.out_char !== owed.out_char ||
                    o_out_data.last_char !== owed.last_char) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected %h/%b, got %h/%b",
                                 $realtime, owed.out_char, owed.last_char,
                                 o_out_data.out_char, o_out_data.last_char);
                    end
                end
            end
        end
    end

    // End the run if neither channel completes a transaction for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles",
                     $realtime, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each group length ending a message, field extremes, every symbol
    // class ('+' and '/' included), and a message that ends one byte into
    // a second group.
    task automatic test_directed();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_message(32'h00_000000, 1);   // single byte, two pads
        send_message(32'hFF_000000, 1);
        send_message(32'hFFFF_0000, 2);   // two bytes, one pad
        send_message(32'h0001_0000, 2);
        send_message(32'h000000_00, 3);   // full group, no pad
        send_message(32'hFFFFFF_00, 3);
        send_message(32'hFBEFBE_00, 3);
        send_message(32'h4D616E_00, 3);
        send_message(32'h4D616E79, 4);    // group then a lone byte
        wait_for_drain();
    endtask

    // Messages of mostly short random length with idling on both sides,
    // switched off now and then for idle-free stretches.
    task automatic test_random_messages(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 9);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            send_random_message(len);
            sent += len;
        end
    endtask

    // Hold the receiver for a long stretch while bytes keep coming, so the
    // queue fills and the block stalls its input.
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_cycles_req = LONG_HOLD;
        send_random_message(17);
        send_random_message(13);
        wait_for_drain();
    endtask

    // Let the block empty completely mid-stream, then resume.
    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_message(5);
        wait_for_drain();
        send_random_message(4);
        wait_for_drain();
        send_random_message(2);
    endtask

    // Full rate on both sides to close the run.
    task automatic test_full_rate_tail();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (8) send_random_message($urandom_range(1, 9));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_backpressure();
        test_random_messages(210);
        test_drain_pause();
        test_full_rate_tail();

        // Wait out the owed characters, then keep waiting to catch
        // anything extra the block might still emit.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
